### hw/rtl/gmds_pkg.sv
// Shared constants, types and helpers for the grid maze depth-first search core.
package gmds_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int MAX_ROWS    = 32;
    localparam int STACK_DEPTH = 4096;

    localparam int COL_W      = $clog2(MAX_COLUMNS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int POS_W      = ROW_W + COL_W;
    localparam int GRID_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int GRID_AW    = $clog2(GRID_DEPTH);
    localparam int STACK_AW   = $clog2(STACK_DEPTH);
    localparam int COUNT_W    = $clog2(STACK_DEPTH + 1);

    localparam int SIZE_W    = 6;
    localparam int CODE_W    = 4;
    localparam int VISIT_W   = 11;
    localparam int SIZE_RESET = 32;

    typedef logic [CODE_W-1:0] code_t;

    localparam code_t CELL_OPEN    = 4'd1;
    localparam code_t CELL_START   = 4'd5;
    localparam code_t CELL_VISITED = 4'd7;
    localparam code_t CELL_EXIT    = 4'd9;

    localparam logic [VISIT_W-1:0] VISIT_MAX = '1;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SEARCH = 2'd1,
        OP_READ   = 2'd2
    } opcode_t;

    // Stack and exit hold row/column pairs so no divide is needed on pop.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } pos_t;

    function automatic logic [GRID_AW-1:0] grid_addr(pos_t p);
        int a;
        a = int'(p.row) * MAX_COLUMNS + int'(p.col);
        return GRID_AW'(a);
    endfunction

    // Bring a size register into 1..maxv.
    function automatic int clamp_size(logic [SIZE_W-1:0] v, int maxv);
        int vi;
        vi = int'(v);
        if (vi < 1) begin
            return 1;
        end
        if (vi > maxv) begin
            return maxv;
        end
        return vi;
    endfunction

endpackage

### hw/rtl/grid_maze_dfs_search_core.sv
// Top level of the grid maze depth-first search core: command channel, FSM, APB registers.
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  ---------------------------------------------
//  cmd       in         in_valid / in_ready     opcode, cell_row, cell_column, cell_value
//  result    out        out_valid / out_ready   exit_found, visited_total, stack_overflowed,
//                                               read_value
//  cfg       in         APB psel/penable/pwrite grid_width @0x0, grid_height @0x4
//
// Flow: a cell write produces no beat; a cell read is taken on the input side, and its beat
// passes the grid RAM read register, then the result register. A search runs an empty-stack
// check, a pop (stack RAM read, mark visited) and, per neighbour, a bounds check followed by
// a grid RAM read and push when the neighbour is in range. No input beat is taken during a
// search.
// Reset: control clears at once; neither RAM is cleared, so there is no clearing pass.
// Stalls: the result register frees the input side, so writes keep flowing while a read
// or search beat waits; a second result waits until the pending one is taken.
module grid_maze_dfs_search_core
    import gmds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           opcode,
    input  logic [4:0]           cell_row,
    input  logic [4:0]           cell_column,
    input  logic [3:0]           cell_value,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 exit_found,
    output logic [VISIT_W-1:0]   visited_total,
    output logic                 stack_overflowed,
    output logic [3:0]           read_value
);

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_VISIT,
        ST_NBR,
        ST_TEST,
        ST_DONE
    } state_t;

    // neighbour order follows the search order: left, right, up, down
    typedef enum logic [1:0] {
        DIR_LEFT,
        DIR_RIGHT,
        DIR_UP,
        DIR_DOWN
    } dir_t;

    state_t               state_reg, state_next;
    dir_t                 dir_reg, dir_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    pos_t                 exit_reg, exit_next;
    logic                 ovf_reg, ovf_next;
    logic [SIZE_W-1:0]    width_reg, width_next;
    logic [SIZE_W-1:0]    height_reg, height_next;
    pos_t                 cur_reg, cur_next;
    pos_t                 cand_reg, cand_next;
    logic [VISIT_W-1:0]   visited_reg, visited_next;
    logic                 found_reg, found_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [VISIT_W-1:0]   out_visited_reg, out_visited_next;
    logic                 out_ovf_reg, out_ovf_next;
    code_t                out_code_reg, out_code_next;

    // RAM ports
    logic                 grid_we, grid_re;
    logic [GRID_AW-1:0]   grid_waddr, grid_raddr;
    code_t                grid_wdata, grid_rdata;
    logic                 stack_we, stack_re;
    logic [STACK_AW-1:0]  stack_waddr, stack_raddr;
    logic [POS_W-1:0]     stack_wdata, stack_rdata;

    logic                 cfg_write;
    logic                 slot_free;
    logic                 in_fire;
    logic                 in_ok;
    pos_t                 in_pos;
    pos_t                 pop_pos;
    logic [COL_W:0]       cols_lim;
    logic [ROW_W:0]       rows_lim;
    logic [COL_W:0]       cur_col_x, nb_col;
    logic [ROW_W:0]       cur_row_x, nb_row;
    logic                 nb_dir_ok, nb_ok;
    pos_t                 nb_pos;
    logic                 push_req;
    pos_t                 push_pos;
    logic [COUNT_W-1:0]   count_dec;

    gmds_ram #(
        .WIDTH (CODE_W),
        .DEPTH (GRID_DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .re    (grid_re),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    gmds_ram #(
        .WIDTH (POS_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // ---------------- APB registers ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_GRID_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, width_reg};
            REG_GRID_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, height_reg};
        endcase
    end

    // ---------------- command decode ----------------
    assign in_ok  = (int'(cell_row) < MAX_ROWS) && (int'(cell_column) < MAX_COLUMNS);
    assign in_pos = '{row: ROW_W'(cell_row), col: COL_W'(cell_column)};

    // result register is free now or at this edge
    assign slot_free = !out_valid_reg || out_ready;
    // a pending read holds the grid RAM data until the result register can take it
    assign in_ready  = (state_reg == ST_IDLE) && (!rd_pend_reg || slot_free);
    assign in_fire   = in_valid && in_ready;

    // ---------------- neighbour candidate ----------------
    assign cols_lim  = (COL_W+1)'(clamp_size(width_reg, MAX_COLUMNS));
    assign rows_lim  = (ROW_W+1)'(clamp_size(height_reg, MAX_ROWS));
    assign cur_col_x = {1'b0, cur_reg.col};
    assign cur_row_x = {1'b0, cur_reg.row};

    always_comb
    begin
        nb_row    = cur_row_x;
        nb_col    = cur_col_x;
        nb_dir_ok = 1'b1;
        unique case (dir_reg)
            DIR_LEFT:
            begin
                nb_dir_ok = (cur_reg.col != '0);
                nb_col    = cur_col_x - 1'b1;
            end
            DIR_RIGHT: nb_col = cur_col_x + 1'b1;
            DIR_UP:
            begin
                nb_dir_ok = (cur_reg.row != '0);
                nb_row    = cur_row_x - 1'b1;
            end
            DIR_DOWN:  nb_row = cur_row_x + 1'b1;
        endcase
    end

    // a start cell outside the configured size still checks both coordinates
    assign nb_ok     = nb_dir_ok && (nb_row < rows_lim) && (nb_col < cols_lim);
    assign nb_pos    = '{row: nb_row[ROW_W-1:0], col: nb_col[COL_W-1:0]};
    assign pop_pos   = pos_t'(stack_rdata);
    assign count_dec = count_reg - 1'b1;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next       = state_reg;
        dir_next         = dir_reg;
        rd_pend_next     = rd_pend_reg;
        rd_ok_next       = rd_ok_reg;
        count_next       = count_reg;
        exit_next        = exit_reg;
        ovf_next         = ovf_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        cur_next         = cur_reg;
        cand_next        = cand_reg;
        visited_next     = visited_reg;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg;
        out_found_next   = out_found_reg;
        out_visited_next = out_visited_reg;
        out_ovf_next     = out_ovf_reg;
        out_code_next    = out_code_reg;

        grid_we     = 1'b0;
        grid_waddr  = grid_addr(in_pos);
        grid_wdata  = code_t'(cell_value);
        grid_re     = 1'b0;
        grid_raddr  = grid_addr(in_pos);
        stack_re    = 1'b0;
        stack_raddr = count_dec[STACK_AW-1:0];
        stack_we    = 1'b0;
        stack_waddr = count_reg[STACK_AW-1:0];
        stack_wdata = in_pos;
        push_req    = 1'b0;
        push_pos    = in_pos;

        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_GRID_WIDTH:  width_next  = pwdata[SIZE_W-1:0];
                REG_GRID_HEIGHT: height_next = pwdata[SIZE_W-1:0];
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (rd_pend_reg && slot_free)
        begin
            rd_pend_next     = 1'b0;
            out_valid_next   = 1'b1;
            out_found_next   = 1'b0;
            out_visited_next = '0;
            out_ovf_next     = 1'b0;
            out_code_next    = rd_ok_reg ? grid_rdata : '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (opcode)
                        OP_WRITE:
                        begin
                            if (in_ok)
                            begin
                                grid_we = 1'b1;
                                if (code_t'(cell_value) == CELL_START)
                                begin
                                    push_req = 1'b1;
                                end
                                else if (code_t'(cell_value) == CELL_EXIT)
                                begin
                                    exit_next = in_pos;
                                end
                            end
                        end
                        OP_SEARCH:
                        begin
                            visited_next = '0;
                            found_next   = 1'b0;
                            state_next   = ST_POP;
                        end
                        OP_READ:
                        begin
                            grid_re      = 1'b1;
                            rd_pend_next = 1'b1;
                            rd_ok_next   = in_ok;
                        end
                        default: ;
                    endcase
                end
            end
            ST_POP:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    stack_re   = 1'b1;
                    count_next = count_dec;
                    state_next = ST_VISIT;
                end
            end
            ST_VISIT:
            begin
                grid_we    = 1'b1;
                grid_waddr = grid_addr(pop_pos);
                grid_wdata = CELL_VISITED;
                if (visited_reg != VISIT_MAX)
                begin
                    visited_next = visited_reg + 1'b1;
                end
                if (pop_pos == exit_reg)
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cur_next   = pop_pos;
                    dir_next   = DIR_LEFT;
                    state_next = ST_NBR;
                end
            end
            ST_NBR:
            begin
                if (nb_ok)
                begin
                    grid_re    = 1'b1;
                    grid_raddr = grid_addr(nb_pos);
                    cand_next  = nb_pos;
                    state_next = ST_TEST;
                end
                else if (dir_reg == DIR_DOWN)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    dir_next = dir_t'(dir_reg + 2'd1);
                end
            end
            ST_TEST:
            begin
                if (grid_rdata == CELL_OPEN || grid_rdata == CELL_EXIT)
                begin
                    push_req = 1'b1;
                    push_pos = cand_reg;
                end
                if (dir_reg == DIR_DOWN)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    dir_next   = dir_t'(dir_reg + 2'd1);
                    state_next = ST_NBR;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_found_next   = found_reg;
                    out_visited_next = visited_reg;
                    out_ovf_next     = ovf_reg;
                    out_code_next    = '0;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // shared push path; a full stack drops the entry and sets the sticky flag
        if (push_req)
        begin
            if (count_reg == COUNT_W'(STACK_DEPTH))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                stack_we    = 1'b1;
                stack_waddr = count_reg[STACK_AW-1:0];
                stack_wdata = push_pos;
                count_next  = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            dir_reg         <= DIR_LEFT;
            rd_pend_reg     <= 1'b0;
            rd_ok_reg       <= 1'b0;
            count_reg       <= '0;
            exit_reg        <= '0;
            ovf_reg         <= 1'b0;
            width_reg       <= SIZE_W'(SIZE_RESET);
            height_reg      <= SIZE_W'(SIZE_RESET);
            cur_reg         <= '0;
            cand_reg        <= '0;
            visited_reg     <= '0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_found_reg   <= 1'b0;
            out_visited_reg <= '0;
            out_ovf_reg     <= 1'b0;
            out_code_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            dir_reg         <= dir_next;
            rd_pend_reg     <= rd_pend_next;
            rd_ok_reg       <= rd_ok_next;
            count_reg       <= count_next;
            exit_reg        <= exit_next;
            ovf_reg         <= ovf_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            cur_reg         <= cur_next;
            cand_reg        <= cand_next;
            visited_reg     <= visited_next;
            found_reg       <= found_next;
            out_valid_reg   <= out_valid_next;
            out_found_reg   <= out_found_next;
            out_visited_reg <= out_visited_next;
            out_ovf_reg     <= out_ovf_next;
            out_code_reg    <= out_code_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign exit_found       = out_found_reg;
    assign visited_total    = out_visited_reg;
    assign stack_overflowed = out_ovf_reg;
    assign read_value       = out_code_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    a_visit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_VISIT |=> visited_reg != '0)
        else $error("pop not counted");

    a_read_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> state_reg == ST_IDLE)
        else $error("read pending during search");

    a_grid_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        grid_we && grid_re |-> grid_waddr != grid_raddr)
        else $error("grid read and write hit one entry");
`endif

endmodule

### hw/rtl/gmds_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module gmds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
